// ===== rtl/clint_pkg.sv =====
// Shared types, codes and constants of the core-local timer interruptor.
// Used by clint_decode, clint_csr and the top level through scoped names; depends on nothing.

package clint_pkg;

    // Default geometry and register offsets of the device window.
    localparam int DEVICE_BYTES_DEF = 65536;
    localparam int SOFT_WORD_AT_DEF = 0;
    localparam int COMPARE_AT_DEF   = 16384;
    localparam int COUNTER_AT_DEF   = 49144;

    // Device base address after reset.
    localparam logic [31:0] DEVICE_BASE_RESET = 32'h0200_0000;

    // Bits of a word index taken from a 32-bit byte offset.
    localparam int WORD_IDX_W = 30;

    typedef enum logic [1:0] {
        OP_READ,
        OP_WRITE,
        OP_TICK,
        OP_CHECK
    } clint_op_t;

    typedef enum logic [1:0] {
        SZ_BYTE,
        SZ_HALF,
        SZ_WORD,
        SZ_NONE
    } clint_size_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_LOAD_MISALIGNED,
        ST_STORE_MISALIGNED
    } clint_status_t;

    // One of the two words touched by an access.
    typedef struct packed {
        logic [WORD_IDX_W-1:0] idx;
        logic                  ok;
        logic [3:0]            be;
        logic [31:0]           data;
    } clint_word_t;

    // What the read stage needs to assemble a read value.
    typedef struct packed {
        logic       lo_odd;
        logic       lo_ok;
        logic       hi_ok;
        logic [1:0] lane;
        logic [3:0] mask;
        logic       rd_ok;
    } clint_rd_meta_t;

    // Register-word values that replace the memory data on a read.
    typedef struct packed {
        logic        lo_hit;
        logic        hi_hit;
        logic [31:0] lo_val;
        logic [31:0] hi_val;
    } clint_ovr_t;

    // Interrupt flags reported with a result.
    typedef struct packed {
        logic timer_pending;
        logic software_pending;
        logic interrupt_taken;
        logic interrupt_cause;
    } clint_flags_t;

    // Byte-lane merge of new data into an old word.
    function automatic logic [31:0] merge_bytes(logic [31:0] old_word, logic [31:0] data,
                                                logic [3:0] be);
        logic [31:0] r;
        r = old_word;
        for (int i = 0; i < 4; i++) begin
            if (be[i]) begin
                r[i*8 +: 8] = data[i*8 +: 8];
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/clint_ram.sv =====
// Generic simple dual-port RAM with byte-lane write enables and registered read.
// Stand-alone; no package needed.

module clint_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic [WIDTH/8-1:0]       we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    localparam int LANES = WIDTH / 8;

    logic [WIDTH-1:0] mem [DEPTH];

    // Byte-lane write and registered read; read data holds when re is low.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++) begin
            if (we[i]) begin
                mem[waddr][i*8 +: 8] <= wdata[i*8 +: 8];
            end
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/clint_decode.sv =====
// Address decode: byte offset, alignment check, lane placement and bank routing.
// Depends on clint_pkg.

module clint_decode #(
    parameter int DEVICE_BYTES = clint_pkg::DEVICE_BYTES_DEF
) (
    input  logic [31:0]                           device_base,
    input  clint_pkg::clint_op_t                  opcode,
    input  logic [31:0]                           address,
    input  clint_pkg::clint_size_t                size_code,
    input  logic [31:0]                           write_data,
    output clint_pkg::clint_word_t                lo,
    output clint_pkg::clint_word_t                hi,
    output clint_pkg::clint_rd_meta_t             meta,
    output clint_pkg::clint_status_t              status,
    output logic [$clog2(DEVICE_BYTES/8)-1:0]     even_row,
    output logic [$clog2(DEVICE_BYTES/8)-1:0]     odd_row,
    output logic [3:0]                            even_be,
    output logic [3:0]                            odd_be,
    output logic [31:0]                           even_wdata,
    output logic [31:0]                           odd_wdata
);

    localparam int WORDS = DEVICE_BYTES / 4;
    localparam int ROWS  = WORDS / 2;
    localparam int ROW_W = $clog2(ROWS);
    localparam int IW    = clint_pkg::WORD_IDX_W;

    logic [31:0]   offset;
    logic [1:0]    lane;
    logic [IW-1:0] w0;
    logic [IW-1:0] w1;
    logic [IW-1:0] even_word;
    logic [IW-1:0] odd_word;
    logic [3:0]    size_mask;
    logic          misaligned;
    logic          access;
    logic          wr;
    logic          lo_ok;
    logic          hi_ok;
    logic [7:0]    pair_be;
    logic [63:0]   pair_data;

    // Access width and alignment on the full address.
    always_comb
    begin
        unique case (size_code)
            clint_pkg::SZ_BYTE:
            begin
                size_mask  = 4'b0001;
                misaligned = 1'b0;
            end
            clint_pkg::SZ_HALF:
            begin
                size_mask  = 4'b0011;
                misaligned = address[0];
            end
            clint_pkg::SZ_WORD:
            begin
                size_mask  = 4'b1111;
                misaligned = |address[1:0];
            end
            clint_pkg::SZ_NONE:
            begin
                size_mask  = 4'b0000;
                misaligned = 1'b0;
            end
        endcase
    end

    // The access covers the low word of the offset and possibly the next one.
    always_comb
    begin
        offset    = address - device_base;
        lane      = offset[1:0];
        w0        = offset[31:2];
        w1        = w0 + IW'(1);
        access    = !misaligned && (size_mask != 4'b0000);
        wr        = (opcode == clint_pkg::OP_WRITE) && access;
        lo_ok     = w0 < IW'(WORDS);
        hi_ok     = w1 < IW'(WORDS);
        pair_be   = {4'b0000, size_mask} << lane;
        pair_data = {32'h0, write_data} << {lane, 3'b000};

        lo.idx  = w0;
        lo.ok   = lo_ok;
        lo.be   = (wr && lo_ok) ? pair_be[3:0] : 4'b0000;
        lo.data = pair_data[31:0];
        hi.idx  = w1;
        hi.ok   = hi_ok;
        hi.be   = (wr && hi_ok) ? pair_be[7:4] : 4'b0000;
        hi.data = pair_data[63:32];

        meta.lo_odd = w0[0];
        meta.lo_ok  = lo_ok;
        meta.hi_ok  = hi_ok;
        meta.lane   = lane;
        meta.mask   = size_mask;
        meta.rd_ok  = (opcode == clint_pkg::OP_READ) && access;

        if (misaligned && (opcode == clint_pkg::OP_READ)) begin
            status = clint_pkg::ST_LOAD_MISALIGNED;
        end else if (misaligned && (opcode == clint_pkg::OP_WRITE)) begin
            status = clint_pkg::ST_STORE_MISALIGNED;
        end else begin
            status = clint_pkg::ST_OK;
        end
    end

    // Even words live in one bank and odd words in the other.
    always_comb
    begin
        even_word  = w0[0] ? w1 : w0;
        odd_word   = w0[0] ? w0 : w1;
        even_row   = even_word[ROW_W:1];
        odd_row    = odd_word[ROW_W:1];
        even_be    = w0[0] ? hi.be : lo.be;
        odd_be     = w0[0] ? lo.be : hi.be;
        even_wdata = w0[0] ? hi.data : lo.data;
        odd_wdata  = w0[0] ? lo.data : hi.data;
    end

endmodule

// ===== rtl/clint_csr.sv =====
// Timer and software registers held next to the store, tick and interrupt check.
// Depends on clint_pkg.

module clint_csr #(
    parameter int DEVICE_BYTES = clint_pkg::DEVICE_BYTES_DEF,
    parameter int SOFT_WORD_AT = clint_pkg::SOFT_WORD_AT_DEF,
    parameter int COMPARE_AT   = clint_pkg::COMPARE_AT_DEF,
    parameter int COUNTER_AT   = clint_pkg::COUNTER_AT_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  clint_pkg::clint_op_t    opcode,
    input  clint_pkg::clint_word_t  lo,
    input  clint_pkg::clint_word_t  hi,
    input  logic                    global_enable,
    input  logic                    soft_enable,
    input  logic                    timer_enable,
    output clint_pkg::clint_ovr_t   ovr,
    output clint_pkg::clint_flags_t flags
);

    localparam int WORDS = DEVICE_BYTES / 4;
    localparam int IW    = clint_pkg::WORD_IDX_W;

    localparam logic [IW-1:0] SOFT_IDX   = IW'(SOFT_WORD_AT / 4);
    localparam logic [IW-1:0] CMP_LO_IDX = IW'(COMPARE_AT / 4);
    localparam logic [IW-1:0] CMP_HI_IDX = IW'(COMPARE_AT / 4 + 1);
    localparam logic [IW-1:0] CNT_LO_IDX = IW'(COUNTER_AT / 4);
    localparam logic [IW-1:0] CNT_HI_IDX = IW'(COUNTER_AT / 4 + 1);
    localparam bit            CNT_LO_IN  = (COUNTER_AT / 4) < WORDS;
    localparam bit            CNT_HI_IN  = (COUNTER_AT / 4 + 1) < WORDS;

    logic [31:0] soft_reg, soft_next;
    logic [31:0] cmp_lo_reg, cmp_lo_next;
    logic [31:0] cmp_hi_reg, cmp_hi_next;
    logic [31:0] cnt_lo_reg, cnt_lo_next;
    logic [31:0] cnt_hi_reg, cnt_hi_next;
    logic        tp_reg, tp_next;
    logic        sp_reg, sp_next;
    logic        cause_reg, cause_next;

    logic [63:0] cnt_inc;
    logic        cnt_ge;
    logic        soft_one;
    logic        take_soft;
    logic        take_timer;
    logic        taken;
    logic        is_tick;

    // Bus write into one register word; a register outside the window never matches.
    function automatic logic [31:0] word_write(logic [31:0] old_word, logic [IW-1:0] idx,
                                               clint_pkg::clint_word_t w_lo,
                                               clint_pkg::clint_word_t w_hi);
        logic [31:0] r;
        r = old_word;
        if (w_lo.ok && (w_lo.idx == idx)) begin
            r = clint_pkg::merge_bytes(r, w_lo.data, w_lo.be);
        end
        if (w_hi.ok && (w_hi.idx == idx)) begin
            r = clint_pkg::merge_bytes(r, w_hi.data, w_hi.be);
        end
        return r;
    endfunction

    // Current value of a register word for a read that lands on it.
    function automatic logic [31:0] word_read(logic [IW-1:0] idx, logic [31:0] soft_w,
                                              logic [31:0] cmp_lo_w, logic [31:0] cmp_hi_w,
                                              logic [31:0] cnt_lo_w, logic [31:0] cnt_hi_w);
        logic [31:0] r;
        r = 32'h0;
        if (idx == SOFT_IDX) begin
            r = soft_w;
        end else if (idx == CMP_LO_IDX) begin
            r = cmp_lo_w;
        end else if (idx == CMP_HI_IDX) begin
            r = cmp_hi_w;
        end else if (idx == CNT_LO_IDX) begin
            r = cnt_lo_w;
        end else if (idx == CNT_HI_IDX) begin
            r = cnt_hi_w;
        end
        return r;
    endfunction

    function automatic logic is_reg_word(clint_pkg::clint_word_t w);
        return w.ok && ((w.idx == SOFT_IDX) || (w.idx == CMP_LO_IDX) ||
                        (w.idx == CMP_HI_IDX) || (w.idx == CNT_LO_IDX) ||
                        (w.idx == CNT_HI_IDX));
    endfunction

    // Read substitution for register words.
    always_comb
    begin
        ovr.lo_hit = is_reg_word(lo);
        ovr.hi_hit = is_reg_word(hi);
        ovr.lo_val = word_read(lo.idx, soft_reg, cmp_lo_reg, cmp_hi_reg, cnt_lo_reg, cnt_hi_reg);
        ovr.hi_val = word_read(hi.idx, soft_reg, cmp_lo_reg, cmp_hi_reg, cnt_lo_reg, cnt_hi_reg);
    end

    // Bus writes, counter tick and pending flags.
    always_comb
    begin
        is_tick  = opcode == clint_pkg::OP_TICK;
        cnt_inc  = {cnt_hi_reg, cnt_lo_reg} + 64'd1;
        cnt_ge   = cnt_inc >= {cmp_hi_reg, cmp_lo_reg};
        soft_one = soft_reg == 32'd1;

        soft_next   = word_write(soft_reg, SOFT_IDX, lo, hi);
        cmp_lo_next = word_write(cmp_lo_reg, CMP_LO_IDX, lo, hi);
        cmp_hi_next = word_write(cmp_hi_reg, CMP_HI_IDX, lo, hi);
        cnt_lo_next = word_write(cnt_lo_reg, CNT_LO_IDX, lo, hi);
        cnt_hi_next = word_write(cnt_hi_reg, CNT_HI_IDX, lo, hi);
        if (is_tick && CNT_LO_IN) begin
            cnt_lo_next = cnt_inc[31:0];
        end
        if (is_tick && CNT_HI_IN) begin
            cnt_hi_next = cnt_inc[63:32];
        end

        tp_next = is_tick ? cnt_ge : tp_reg;
        sp_next = sp_reg | (is_tick & soft_one);
    end

    // Interrupt check, software ahead of timer.
    always_comb
    begin
        take_soft  = global_enable && soft_one && soft_enable;
        take_timer = global_enable && !take_soft && tp_reg && timer_enable;
        taken      = (opcode == clint_pkg::OP_CHECK) && (take_soft || take_timer);
        cause_next = taken ? take_timer : cause_reg;

        flags.timer_pending    = tp_next;
        flags.software_pending = sp_next;
        flags.interrupt_taken  = taken;
        flags.interrupt_cause  = cause_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            soft_reg   <= 32'h0;
            cmp_lo_reg <= 32'h0;
            cmp_hi_reg <= 32'h0;
            cnt_lo_reg <= 32'h0;
            cnt_hi_reg <= 32'h0;
            tp_reg     <= 1'b0;
            sp_reg     <= 1'b0;
            cause_reg  <= 1'b0;
        end else if (accept) begin
            soft_reg   <= soft_next;
            cmp_lo_reg <= cmp_lo_next;
            cmp_hi_reg <= cmp_hi_next;
            cnt_lo_reg <= cnt_lo_next;
            cnt_hi_reg <= cnt_hi_next;
            tp_reg     <= tp_next;
            sp_reg     <= sp_next;
            cause_reg  <= cause_next;
        end
    end

endmodule

// ===== rtl/core_local_timer_interruptor_unit.sv =====
// Top level of the core-local timer interruptor: streams, store banks, read stage.
// Depends on clint_pkg, clint_ram, clint_decode and clint_csr.

// The block takes one beat per cycle on s_axis while s_axis_tready is high, and returns
// exactly one result beat for each, in order. A beat passes the synchronous read of the
// two word banks (even and odd words, so an access that straddles a word boundary is
// served in one read) and then the output register; s_axis_tready drops while m_axis
// stalls with both stages full. The store is cleared by a sweep after reset that writes
// one row of both banks per cycle; s_axis_tready stays low until it ends, while cfg
// writes are taken at any time. The software, compare and counter words are also held
// in registers beside the banks, so a tick updates the counter and the pending flags in
// its own cycle. Register offsets must be multiples of four and must not overlap;
// DEVICE_BYTES must be a multiple of eight.

module core_local_timer_interruptor_unit #(
    parameter int DEVICE_BYTES = clint_pkg::DEVICE_BYTES_DEF,
    parameter int SOFT_WORD_AT = clint_pkg::SOFT_WORD_AT_DEF,
    parameter int COMPARE_AT   = clint_pkg::COMPARE_AT_DEF,
    parameter int COUNTER_AT   = clint_pkg::COUNTER_AT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: device_base.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // Input beats.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // address[31:0], size_code[33:32], write_data[65:34], global_enable[66],
    // soft_enable[67], timer_enable[68], zero[71:69]
    input  logic [71:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    // Result beats.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[31:0], status[33:32], timer_pending[34], software_pending[35],
    // interrupt_taken[36], interrupt_cause[37], zero[39:38]
    output logic [39:0] m_axis_tdata
);

    localparam int ROWS  = DEVICE_BYTES / 8;
    localparam int ROW_W = $clog2(ROWS);

    logic [31:0]      device_base_reg;
    logic             clear_active_reg, clear_active_next;
    logic [ROW_W-1:0] clear_row_reg, clear_row_next;

    logic accept;
    logic s1_adv;

    // Decoded input beat.
    clint_pkg::clint_op_t      in_opcode;
    clint_pkg::clint_size_t    in_size;
    clint_pkg::clint_word_t    dec_lo;
    clint_pkg::clint_word_t    dec_hi;
    clint_pkg::clint_rd_meta_t dec_meta;
    clint_pkg::clint_status_t  dec_status;
    clint_pkg::clint_ovr_t     csr_ovr;
    clint_pkg::clint_flags_t   csr_flags;
    logic [ROW_W-1:0]          even_row;
    logic [ROW_W-1:0]          odd_row;
    logic [3:0]                even_be;
    logic [3:0]                odd_be;
    logic [31:0]               even_wdata;
    logic [31:0]               odd_wdata;

    // Bank ports.
    logic [3:0]       even_we;
    logic [3:0]       odd_we;
    logic [ROW_W-1:0] even_waddr;
    logic [ROW_W-1:0] odd_waddr;
    logic [31:0]      even_wd;
    logic [31:0]      odd_wd;
    logic [31:0]      even_q;
    logic [31:0]      odd_q;

    // Read stage.
    logic                      s1_valid_reg, s1_valid_next;
    clint_pkg::clint_rd_meta_t s1_meta_reg;
    clint_pkg::clint_ovr_t     s1_ovr_reg;
    clint_pkg::clint_status_t  s1_status_reg;
    clint_pkg::clint_flags_t   s1_flags_reg;
    logic [31:0]               lo_ram;
    logic [31:0]               hi_ram;
    logic [31:0]               lo_word;
    logic [31:0]               hi_word;
    logic [63:0]               shifted;
    logic [31:0]               byte_keep;
    logic [31:0]               rd_value;

    // Output register.
    logic                     out_valid_reg, out_valid_next;
    logic [31:0]              out_rdata_reg;
    clint_pkg::clint_status_t out_status_reg;
    clint_pkg::clint_flags_t  out_flags_reg;

    assign in_opcode = clint_pkg::clint_op_t'(s_axis_tuser);
    assign in_size   = clint_pkg::clint_size_t'(s_axis_tdata[33:32]);

    // Handshakes.
    assign cfg_ready     = 1'b1;
    assign s1_adv        = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !clear_active_reg && (!s1_valid_reg || s1_adv);
    assign accept        = s_axis_tvalid && s_axis_tready;

    clint_decode #(
        .DEVICE_BYTES(DEVICE_BYTES)
    ) u_decode (
        .device_base(device_base_reg),
        .opcode     (in_opcode),
        .address    (s_axis_tdata[31:0]),
        .size_code  (in_size),
        .write_data (s_axis_tdata[65:34]),
        .lo         (dec_lo),
        .hi         (dec_hi),
        .meta       (dec_meta),
        .status     (dec_status),
        .even_row   (even_row),
        .odd_row    (odd_row),
        .even_be    (even_be),
        .odd_be     (odd_be),
        .even_wdata (even_wdata),
        .odd_wdata  (odd_wdata)
    );

    clint_csr #(
        .DEVICE_BYTES(DEVICE_BYTES),
        .SOFT_WORD_AT(SOFT_WORD_AT),
        .COMPARE_AT  (COMPARE_AT),
        .COUNTER_AT  (COUNTER_AT)
    ) u_csr (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .opcode       (in_opcode),
        .lo           (dec_lo),
        .hi           (dec_hi),
        .global_enable(s_axis_tdata[66]),
        .soft_enable  (s_axis_tdata[67]),
        .timer_enable (s_axis_tdata[68]),
        .ovr          (csr_ovr),
        .flags        (csr_flags)
    );

    // Bank writes: the clearing sweep, then accepted bus writes.
    always_comb
    begin
        if (clear_active_reg) begin
            even_we    = 4'hF;
            odd_we     = 4'hF;
            even_waddr = clear_row_reg;
            odd_waddr  = clear_row_reg;
            even_wd    = 32'h0;
            odd_wd     = 32'h0;
        end else begin
            even_we    = accept ? even_be : 4'h0;
            odd_we     = accept ? odd_be : 4'h0;
            even_waddr = even_row;
            odd_waddr  = odd_row;
            even_wd    = even_wdata;
            odd_wd     = odd_wdata;
        end
    end

    clint_ram #(
        .WIDTH(32),
        .DEPTH(ROWS)
    ) u_even_bank (
        .clk  (clk),
        .we   (even_we),
        .waddr(even_waddr),
        .wdata(even_wd),
        .re   (accept),
        .raddr(even_row),
        .rdata(even_q)
    );

    clint_ram #(
        .WIDTH(32),
        .DEPTH(ROWS)
    ) u_odd_bank (
        .clk  (clk),
        .we   (odd_we),
        .waddr(odd_waddr),
        .wdata(odd_wd),
        .re   (accept),
        .raddr(odd_row),
        .rdata(odd_q)
    );

    // Clearing sweep after reset.
    always_comb
    begin
        clear_active_next = clear_active_reg;
        clear_row_next    = clear_row_reg;
        if (clear_active_reg) begin
            clear_row_next = clear_row_reg + ROW_W'(1);
            if (clear_row_reg == ROW_W'(ROWS - 1)) begin
                clear_active_next = 1'b0;
            end
        end
    end

    // Read value from the bank data, register words and window limits.
    always_comb
    begin
        lo_ram    = s1_meta_reg.lo_odd ? odd_q : even_q;
        hi_ram    = s1_meta_reg.lo_odd ? even_q : odd_q;
        lo_word   = !s1_meta_reg.lo_ok ? 32'h0 : (s1_ovr_reg.lo_hit ? s1_ovr_reg.lo_val : lo_ram);
        hi_word   = !s1_meta_reg.hi_ok ? 32'h0 : (s1_ovr_reg.hi_hit ? s1_ovr_reg.hi_val : hi_ram);
        shifted   = {hi_word, lo_word} >> {s1_meta_reg.lane, 3'b000};
        byte_keep = {{8{s1_meta_reg.mask[3]}}, {8{s1_meta_reg.mask[2]}},
                     {8{s1_meta_reg.mask[1]}}, {8{s1_meta_reg.mask[0]}}};
        rd_value  = s1_meta_reg.rd_ok ? (shifted[31:0] & byte_keep) : 32'h0;
    end

    // Stage valid bits.
    always_comb
    begin
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
        out_valid_next = s1_adv ? s1_valid_reg : out_valid_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            device_base_reg  <= clint_pkg::DEVICE_BASE_RESET;
            clear_active_reg <= 1'b1;
            clear_row_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                device_base_reg <= cfg_data;
            end
            clear_active_reg <= clear_active_next;
            clear_row_reg    <= clear_row_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers of the read stage and the output.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_meta_reg   <= dec_meta;
            s1_ovr_reg    <= csr_ovr;
            s1_status_reg <= dec_status;
            s1_flags_reg  <= csr_flags;
        end
        if (s1_adv && s1_valid_reg) begin
            out_rdata_reg  <= rd_value;
            out_status_reg <= s1_status_reg;
            out_flags_reg  <= s1_flags_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00,
                            out_flags_reg.interrupt_cause,
                            out_flags_reg.interrupt_taken,
                            out_flags_reg.software_pending,
                            out_flags_reg.timer_pending,
                            out_status_reg,
                            out_rdata_reg};

endmodule
